### hdl/psx_pkg.sv
// Package: constants, types and helpers shared by the stream expander.
`default_nettype none
package psx_pkg;

  localparam int unsigned SampleDepth = 65536;
  localparam int unsigned AddrW = $clog2(SampleDepth);

  localparam logic [7:0] CmdDacWrite = 8'h52;
  localparam logic [7:0] DacPort     = 8'h2A;
  localparam logic [7:0] CmdWaitLong = 8'h61;
  localparam logic [7:0] CmdEnd      = 8'h66;
  localparam logic [7:0] CmdBlock    = 8'h67;
  localparam logic [7:0] CmdWaitShrt = 8'h70;
  localparam logic [7:0] CmdSample   = 8'h80;
  localparam logic [7:0] CmdSeek     = 8'hE0;
  localparam logic [7:0] HiNibble    = 8'hF0;
  localparam logic [7:0] LoNibble    = 8'h0F;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadHeader = 3'd1;
  localparam logic [2:0] StSecond    = 3'd2;
  localparam logic [2:0] StRange     = 3'd3;
  localparam logic [2:0] StTooBig    = 3'd4;

  localparam logic [0:0] RegShortDelays = 1'b0;

  typedef enum logic [3:0] {
    PhIdle, PhBlkSecond, PhBlkType, PhSampleLen, PhSampleData,
    PhForeignLen, PhSeek, PhPass
  } phase_e;

  typedef enum logic [1:0] {EmIdle, EmRead, EmSend} emit_e;

  // total byte count of a plain command, first byte included
  function automatic logic [2:0] plain_length(input logic [7:0] cmd);
    logic [2:0] len;
    case (cmd[7:4])
      4'h3, 4'h4: len = 3'd2;
      4'h5, 4'hA, 4'hB: len = 3'd3;
      4'hC, 4'hD: len = 3'd4;
      4'hE, 4'hF: len = 3'd5;
      default: len = 3'd1;
    endcase
    if (cmd == 8'h50 || cmd == 8'h64) len = 3'd2;
    if (cmd == CmdWaitLong) len = 3'd3;
    return len;
  endfunction

endpackage
`default_nettype wire

### hdl/psx_stream_if.sv
// Interface: valid/ready channel carrying stream items.
`default_nettype none
interface psx_stream_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  logic         mark;
  logic         last;
  logic [2:0]   status;
  modport source(output valid, data, mark, last, status, input ready);
  modport sink(input valid, data, mark, last, status, output ready);
endinterface
`default_nettype wire

### hdl/psx_sample_ram.sv
// Sample store: single-port synchronous memory, registered read.
`default_nettype none
module psx_sample_ram
  import psx_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [7:0]       wdata_i,
  output logic      [7:0]       rdata_o
);
  logic [7:0] mem [SampleDepth];

  // read one entry, and write it when enabled
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### hdl/pcm_reference_stream_expander.sv
// Top level: command parser, sample store and output sequencer.
//
// Takes one stream byte per request and emits up to six expanded bytes, one
// per cycle while the output is ready. A byte that causes results holds off
// further requests until its last result is sent. A sample command first
// reads the sample store. The output register lets the next request be
// taken while the last result of the previous one waits. Short-delay mode
// is written over the APB port; the user must do so only while idle, as
// the block does not enforce it. No clearing pass is needed.
`default_nettype none
module pcm_reference_stream_expander
  import psx_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  psx_stream_if.sink       in_if,
  psx_stream_if.source     out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  logic short_q;
  phase_e ph_q, ph_d;
  logic [31:0] rem_q, rem_d, acc_q, acc_d, pos_q, pos_d, cnt_q, cnt_d;
  logic [7:0] hdr0_q, hdr0_d, hdr1_q, hdr1_d;
  logic pvalid_q, pvalid_d, loaded_q, loaded_d;
  logic [2:0] err_q, err_d;

  // result buffer
  logic [7:0] buf_q [6], buf_d [6];
  logic [2:0] nres_q, nres_d, idx_q, idx_d;
  logic       rdpend_q, rdpend_d;
  logic [2:0] bstat_q, bstat_d;
  emit_e em_q, em_d;

  logic        ov_q, ov_d, olast_q, olast_d;
  logic [7:0]  ob_q, ob_d;
  logic [2:0]  ost_q, ost_d;

  logic        we;
  logic [AddrW-1:0] addr;
  logic [7:0]  rdata;

  logic        acc_in;
  logic [7:0]  b;
  logic [31:0] gath;
  logic [3:0]  wt;
  logic [2:0]  plen;

  // config port
  assign pready = 1'b1;
  assign prdata = {31'd0, short_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) short_q <= 1'b0;
    else if (psel && penable && pwrite && paddr == {RegShortDelays, 1'b0} )
      short_q <= pwdata[0];
  end

  psx_sample_ram u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(b), .rdata_o(rdata)
  );

  // take a request when no results are pending
  logic out_free;
  assign out_free = !ov_q || out_if.ready;
  assign in_if.ready = (em_q == EmIdle);
  assign acc_in = in_if.valid && in_if.ready;
  assign b = in_if.data;
  assign gath = acc_q | ({24'd0, b} << {rem_q[1:0], 3'b000});
  assign wt = b[3:0];
  assign plen = plain_length(b);

  // parse one byte
  always_comb begin
    ph_d = ph_q; rem_d = rem_q; acc_d = acc_q; pos_d = pos_q; cnt_d = cnt_q;
    hdr0_d = hdr0_q; hdr1_d = hdr1_q; pvalid_d = pvalid_q; loaded_d = loaded_q;
    err_d = err_q;
    for (int i = 0; i < 6; i++) buf_d[i] = buf_q[i];
    nres_d = 3'd0; rdpend_d = 1'b0; bstat_d = StOk;
    we = 1'b0;
    addr = pos_q[AddrW-1:0];
    if (err_q != StOk) begin
      nres_d = 3'd1; bstat_d = err_q; buf_d[0] = 8'd0;
    end else begin
      case (ph_q)
        PhBlkSecond: begin hdr1_d = b; ph_d = PhBlkType; end
        PhBlkType: begin
          acc_d = 32'd0; rem_d = 32'd0;
          if (b == 8'd0) begin
            if (hdr1_q != CmdEnd) err_d = StBadHeader;
            else if (loaded_q) err_d = StSecond;
            else begin loaded_d = 1'b1; cnt_d = 32'd0; ph_d = PhSampleLen; end
          end else begin
            buf_d[0] = hdr0_q; buf_d[1] = hdr1_q; buf_d[2] = b;
            nres_d = 3'd3; ph_d = PhForeignLen;
          end
        end
        PhSampleLen: begin
          acc_d = gath; rem_d = rem_q + 32'd1;
          if (rem_q[1:0] == 2'd3) begin
            if (gath > 32'(SampleDepth)) err_d = StTooBig;
            else begin rem_d = gath; ph_d = (gath != 0) ? PhSampleData : PhIdle; end
          end
        end
        PhSampleData: begin
          we = (cnt_q < 32'(SampleDepth));
          addr = cnt_q[AddrW-1:0];
          cnt_d = cnt_q + 32'd1; rem_d = rem_q - 32'd1;
          if (rem_q == 32'd1) ph_d = PhIdle;
        end
        PhForeignLen: begin
          buf_d[0] = b; nres_d = 3'd1;
          acc_d = gath; rem_d = rem_q + 32'd1;
          if (rem_q[1:0] == 2'd3) begin
            rem_d = gath; ph_d = (gath != 0) ? PhPass : PhIdle;
          end
        end
        PhSeek: begin
          acc_d = gath; rem_d = rem_q + 32'd1;
          if (rem_q[1:0] == 2'd3) begin
            pos_d = gath; pvalid_d = 1'b1; ph_d = PhIdle;
          end
        end
        PhPass: begin
          buf_d[0] = b; nres_d = 3'd1;
          if (rem_q != 0) rem_d = rem_q - 32'd1;
          if (rem_q <= 32'd1) ph_d = PhIdle;
        end
        default: begin
          ph_d = PhIdle;
          if (in_if.mark) pvalid_d = 1'b0;
          if (b == CmdBlock) begin
            hdr0_d = b; ph_d = PhBlkSecond;
          end else if (b == CmdSeek) begin
            acc_d = 32'd0; rem_d = 32'd0; ph_d = PhSeek;
          end else if ((b & HiNibble) == CmdSample) begin
            if (in_if.mark || !pvalid_q || pos_q >= cnt_q ||
                pos_q >= 32'(SampleDepth)) err_d = StRange;
            else begin
              rdpend_d = 1'b1; pos_d = pos_q + 32'd1;
              buf_d[0] = CmdDacWrite; buf_d[1] = DacPort;
              if (wt == 4'd0) nres_d = 3'd3;
              else if (short_q) begin
                nres_d = 3'd4; buf_d[3] = CmdWaitShrt + {4'd0, wt} - 8'd1;
              end else begin
                nres_d = 3'd6; buf_d[3] = CmdWaitLong;
                buf_d[4] = {4'd0, wt}; buf_d[5] = 8'd0;
              end
            end
          end else if ((b & HiNibble) == CmdWaitShrt && !short_q) begin
            nres_d = 3'd3; buf_d[0] = CmdWaitLong;
            buf_d[1] = {4'd0, wt} + 8'd1; buf_d[2] = 8'd0;
          end else begin
            nres_d = 3'd1; buf_d[0] = b;
            if (plen > 3'd1) begin rem_d = {29'd0, plen - 3'd1}; ph_d = PhPass; end
          end
        end
      endcase
      if (err_d != StOk) begin
        nres_d = 3'd1; bstat_d = err_d; buf_d[0] = 8'd0;
      end
    end
    if (!acc_in) begin
      ph_d = ph_q; rem_d = rem_q; acc_d = acc_q; pos_d = pos_q; cnt_d = cnt_q;
      hdr0_d = hdr0_q; hdr1_d = hdr1_q; pvalid_d = pvalid_q; loaded_d = loaded_q;
      err_d = err_q; we = 1'b0;
      for (int i = 0; i < 6; i++) buf_d[i] = buf_q[i];
      nres_d = nres_q; rdpend_d = rdpend_q; bstat_d = bstat_q;
    end
    if (rdpend_q && em_q == EmRead) buf_d[2] = rdata;
  end

  // emit sequencer next state
  always_comb begin
    em_d = em_q;
    case (em_q)
      EmIdle: if (acc_in && nres_d != 0) em_d = rdpend_d ? EmRead : EmSend;
      EmRead: em_d = EmSend;
      EmSend: if (out_free && idx_q == nres_q - 3'd1) em_d = EmIdle;
      default: em_d = EmIdle;
    endcase
  end

  // emit sequencer outputs
  always_comb begin
    idx_d = idx_q; ov_d = ov_q; ob_d = ob_q; olast_d = olast_q; ost_d = ost_q;
    if (out_if.ready) ov_d = 1'b0;
    case (em_q)
      EmIdle: idx_d = 3'd0;
      EmSend: if (out_free) begin
        ov_d = 1'b1; ob_d = buf_q[idx_q]; ost_d = bstat_q;
        olast_d = (idx_q == nres_q - 3'd1); idx_d = idx_q + 3'd1;
      end
      default: ;
    endcase
  end

  assign out_if.valid = ov_q;
  assign out_if.data = ob_q;
  assign out_if.last = olast_q;
  assign out_if.status = ost_q;
  assign out_if.mark = 1'b0;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; rem_q <= '0; acc_q <= '0; pos_q <= '0; cnt_q <= '0;
      pvalid_q <= 1'b0; loaded_q <= 1'b0; err_q <= StOk;
      em_q <= EmIdle; idx_q <= '0; nres_q <= '0; rdpend_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      ph_q <= ph_d; rem_q <= rem_d; acc_q <= acc_d; pos_q <= pos_d; cnt_q <= cnt_d;
      pvalid_q <= pvalid_d; loaded_q <= loaded_d; err_q <= err_d;
      em_q <= em_d; idx_q <= idx_d; nres_q <= nres_d; rdpend_q <= rdpend_d;
      ov_q <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hdr0_q <= hdr0_d; hdr1_q <= hdr1_d; bstat_q <= bstat_d;
    for (int i = 0; i < 6; i++) buf_q[i] <= buf_d[i];
    ob_q <= ob_d; olast_q <= olast_d; ost_q <= ost_d;
  end
endmodule
`default_nettype wire
